// ===== hw/rtl/mpsm_pkg.sv =====
// ----------------------------------------------------------------------------
// mpsm_pkg
// Shared sizes, request actions, node word layout and result codes of the multi-pattern
// string matcher.
// ----------------------------------------------------------------------------
package mpsm_pkg;

    localparam int NODE_COUNT      = 1024;
    localparam int MAX_PATTERN_LEN = 16;
    localparam int MAX_PATTERNS    = 256;
    localparam int SYMBOL_BITS     = 16;
    localparam int RESULT_CAP      = 16;

    localparam int NODE_W = $clog2(NODE_COUNT);
    localparam int CNT_W  = $clog2(NODE_COUNT + 1);
    localparam int LEN_W  = $clog2(MAX_PATTERN_LEN + 1);
    localparam int PAT_W  = $clog2(MAX_PATTERNS + 1);
    localparam int RES_W  = $clog2(RESULT_CAP + 1);
    localparam int ID_W   = 8;

    // Actions of an input request
    localparam logic [1:0] ACT_PATTERN = 2'd0;
    localparam logic [1:0] ACT_BUILD   = 2'd1;
    localparam logic [1:0] ACT_TEXT    = 2'd2;

    // Result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_MATCH     = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_TOO_LONG  = 3'd3;
    localparam logic [2:0] ST_BAD_SYM   = 3'd4;

    // One trie node as kept in the node memory
    typedef struct packed {
        logic [SYMBOL_BITS-1:0] sym;
        logic [NODE_W-1:0]      child;
        logic [NODE_W-1:0]      sib;
        logic [NODE_W-1:0]      fail;
        logic                   is_end;
        logic [LEN_W-1:0]       len;
        logic [ID_W-1:0]        num;
    } node_t;

endpackage

// ===== hw/rtl/multi_pattern_string_matcher.sv =====
// ----------------------------------------------------------------------------
// multi_pattern_string_matcher
// Aho-Corasick matcher: builds a trie of patterns, links failure edges
// breadth-first and reports up to RESULT_CAP patterns ending at each text symbol.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries action, symbol, pattern_last
//   and text_start. Output channel (out_valid/out_ready) carries status,
//   pattern_id, start_pos, end_pos and last_result; last_result marks the
//   final result of a request.
//   One request is worked on at a time; in_ready is high in the idle state,
//   also while a finished result still sits in the output register.
//   Work is paced by the node memory (one read port and one write port, one read
//   per cycle, registered read output):
//     pattern symbol : scans the parent's child list; a new node under a non-root
//                      parent takes an extra link write
//     text symbol    : scans child lists over failure hops, then walks the failure chain
//     build          : reads each queued node and each child, plus the
//                      child scans of every failure search; grows with trie size
//   A stalled receiver holds the walk: the next result waits in a pending
//   register until the output register frees.
//   Reset empties the trie (root only) and clears cursor, counters, match
//   state and text position; the memories are not swept.
// ----------------------------------------------------------------------------
module multi_pattern_string_matcher (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [1:0]                      action,
    input  logic [mpsm_pkg::SYMBOL_BITS-1:0] symbol,
    input  logic                            pattern_last,
    input  logic                            text_start,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [2:0]                      status,
    output logic [7:0]                      pattern_id,
    output logic [31:0]                     start_pos,
    output logic [31:0]                     end_pos,
    output logic                            last_result
);
    import mpsm_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_CS_HEAD  = 4'd1;
    localparam logic [3:0] S_CS_SCAN  = 4'd2;
    localparam logic [3:0] S_INS_POST = 4'd3;
    localparam logic [3:0] S_INS_LINK = 4'd4;
    localparam logic [3:0] S_TX_STEP  = 4'd5;
    localparam logic [3:0] S_TX_WALK  = 4'd6;
    localparam logic [3:0] S_TX_FIN   = 4'd7;
    localparam logic [3:0] S_B_POP    = 4'd8;
    localparam logic [3:0] S_B_QW     = 4'd9;
    localparam logic [3:0] S_B_NW     = 4'd10;
    localparam logic [3:0] S_B_KW     = 4'd11;
    localparam logic [3:0] S_B_FS     = 4'd12;
    localparam logic [3:0] S_B_WR     = 4'd13;
    localparam logic [3:0] S_DONE     = 4'd14;

    // Memories
    node_t             node_mem [NODE_COUNT];
    logic [NODE_W-1:0] queue_mem [NODE_COUNT];

    node_t             nm_q_reg;
    logic              rd_root_reg;
    logic [NODE_W-1:0] qm_q_reg;

    logic              nm_re;
    logic [NODE_W-1:0] nm_raddr;
    logic              nm_we;
    logic [NODE_W-1:0] nm_waddr;
    node_t             nm_wdata;
    logic              qm_re;
    logic [NODE_W-1:0] qm_raddr;
    logic              qm_we;
    logic [NODE_W-1:0] qm_waddr;
    logic [NODE_W-1:0] qm_wdata;

    // Control state
    logic [3:0]        state_reg, state_next;
    logic [NODE_W-1:0] root_child_reg, root_child_next;
    logic [CNT_W-1:0]  nodes_used_reg, nodes_used_next;
    logic [NODE_W-1:0] cursor_reg, cursor_next;
    logic [LEN_W-1:0]  depth_reg, depth_next;
    logic [PAT_W-1:0]  patterns_reg, patterns_next;
    logic [NODE_W-1:0] match_state_reg, match_state_next;
    logic [31:0]       text_pos_reg, text_pos_next;

    // Child search unit
    logic [SYMBOL_BITS-1:0] cs_sym_reg, cs_sym_next;
    logic [3:0]             cs_ret_reg, cs_ret_next;
    logic [NODE_W-1:0]      cs_cur_reg, cs_cur_next;
    logic [NODE_W-1:0]      cs_found_reg, cs_found_next;
    node_t                  cs_head_reg, cs_head_next;
    node_t                  cs_word_reg, cs_word_next;

    // Request context
    logic              last_reg, last_next;
    logic [NODE_W-1:0] link_addr_reg, link_addr_next;
    node_t             link_word_reg, link_word_next;
    logic [2:0]        res_status_reg, res_status_next;
    logic [ID_W-1:0]   res_id_reg, res_id_next;
    logic [NODE_W-1:0] node_reg, node_next;
    logic [31:0]       pos_reg, pos_next;
    logic [RES_W-1:0]  cnt_reg, cnt_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [ID_W-1:0]   pend_id_reg, pend_id_next;
    logic [31:0]       pend_sp_reg, pend_sp_next;
    logic [CNT_W-1:0]  head_reg, head_next;
    logic [CNT_W-1:0]  tail_reg, tail_next;
    logic [NODE_W-1:0] nfail_reg, nfail_next;
    logic [NODE_W-1:0] bf_reg, bf_next;
    node_t             kword_reg, kword_next;

    // Output register
    logic              out_valid_reg, out_valid_next;
    logic [2:0]        status_reg, status_next;
    logic [ID_W-1:0]   id_reg, id_next;
    logic [31:0]       sp_reg, sp_next;
    logic [31:0]       ep_reg, ep_next;
    logic              olast_reg, olast_next;

    node_t             rword;
    node_t             root_word;
    logic              out_free;
    logic              push;
    logic [2:0]        push_status;
    logic [ID_W-1:0]   push_id;
    logic [31:0]       push_sp;
    logic [31:0]       push_ep;
    logic              push_last;
    logic [LEN_W-1:0]  depth_inc;
    logic [NODE_W-1:0] nxt_idx;
    logic [31:0]       tx_pos;
    logic [NODE_W-1:0] tx_state;

    // Root lives in registers; memory entry 0 is never used
    always_comb
    begin
        root_word       = '0;
        root_word.child = root_child_reg;
        rword           = rd_root_reg ? root_word : nm_q_reg;
    end

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign depth_inc = depth_reg + LEN_W'(1);
    assign nxt_idx   = nodes_used_reg[NODE_W-1:0];
    assign tx_pos    = text_start ? 32'd0 : text_pos_reg;
    assign tx_state  = text_start ? '0 : match_state_reg;

    // Sequencer
    always_comb
    begin
        state_next       = state_reg;
        root_child_next  = root_child_reg;
        nodes_used_next  = nodes_used_reg;
        cursor_next      = cursor_reg;
        depth_next       = depth_reg;
        patterns_next    = patterns_reg;
        match_state_next = match_state_reg;
        text_pos_next    = text_pos_reg;
        cs_sym_next      = cs_sym_reg;
        cs_ret_next      = cs_ret_reg;
        cs_cur_next      = cs_cur_reg;
        cs_found_next    = cs_found_reg;
        cs_head_next     = cs_head_reg;
        cs_word_next     = cs_word_reg;
        last_next        = last_reg;
        link_addr_next   = link_addr_reg;
        link_word_next   = link_word_reg;
        res_status_next  = res_status_reg;
        res_id_next      = res_id_reg;
        node_next        = node_reg;
        pos_next         = pos_reg;
        cnt_next         = cnt_reg;
        pend_valid_next  = pend_valid_reg;
        pend_id_next     = pend_id_reg;
        pend_sp_next     = pend_sp_reg;
        head_next        = head_reg;
        tail_next        = tail_reg;
        nfail_next       = nfail_reg;
        bf_next          = bf_reg;
        kword_next       = kword_reg;
        nm_re            = 1'b0;
        nm_raddr         = '0;
        nm_we            = 1'b0;
        nm_waddr         = '0;
        nm_wdata         = '0;
        qm_re            = 1'b0;
        qm_raddr         = '0;
        qm_we            = 1'b0;
        qm_waddr         = '0;
        qm_wdata         = '0;
        push             = 1'b0;
        push_status      = ST_OK;
        push_id          = '0;
        push_sp          = '0;
        push_ep          = '0;
        push_last        = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    res_status_next = ST_OK;
                    res_id_next     = '0;
                    case (action)
                        ACT_PATTERN:
                        begin
                            last_next = pattern_last;
                            if (symbol == '0)
                            begin
                                res_status_next = ST_BAD_SYM;
                                state_next      = S_DONE;
                            end
                            else if (depth_reg >= LEN_W'(MAX_PATTERN_LEN))
                            begin
                                cursor_next     = '0;
                                depth_next      = '0;
                                res_status_next = ST_TOO_LONG;
                                state_next      = S_DONE;
                            end
                            else if (pattern_last && patterns_reg >= PAT_W'(MAX_PATTERNS))
                            begin
                                cursor_next     = '0;
                                depth_next      = '0;
                                res_status_next = ST_FULL;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                nm_re       = 1'b1;
                                nm_raddr    = cursor_reg;
                                cs_sym_next = symbol;
                                cs_ret_next = S_INS_POST;
                                state_next  = S_CS_HEAD;
                            end
                        end
                        ACT_BUILD:
                        begin
                            // seed the queue with the root
                            qm_we      = 1'b1;
                            qm_waddr   = '0;
                            qm_wdata   = '0;
                            head_next  = '0;
                            tail_next  = CNT_W'(1);
                            state_next = S_B_POP;
                        end
                        ACT_TEXT:
                        begin
                            pos_next         = tx_pos;
                            text_pos_next    = tx_pos + 32'd1;
                            match_state_next = tx_state;
                            node_next        = tx_state;
                            cnt_next         = '0;
                            pend_valid_next  = 1'b0;
                            nm_re            = 1'b1;
                            nm_raddr         = tx_state;
                            cs_sym_next      = symbol;
                            cs_ret_next      = S_TX_STEP;
                            state_next       = S_CS_HEAD;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            // Child search: parent word arrives, start on its child list
            S_CS_HEAD:
            begin
                cs_head_next = rword;
                if (rword.child == '0)
                begin
                    cs_found_next = '0;
                    state_next    = cs_ret_reg;
                end
                else
                begin
                    nm_re       = 1'b1;
                    nm_raddr    = rword.child;
                    cs_cur_next = rword.child;
                    state_next  = S_CS_SCAN;
                end
            end

            S_CS_SCAN:
            begin
                if (rword.sym == cs_sym_reg)
                begin
                    cs_found_next = cs_cur_reg;
                    cs_word_next  = rword;
                    state_next    = cs_ret_reg;
                end
                else if (rword.sib == '0)
                begin
                    cs_found_next = '0;
                    state_next    = cs_ret_reg;
                end
                else
                begin
                    nm_re       = 1'b1;
                    nm_raddr    = rword.sib;
                    cs_cur_next = rword.sib;
                end
            end

            // Insert: allocate or reuse the child, mark the pattern end
            S_INS_POST:
            begin
                state_next = S_DONE;
                if (cs_found_reg == '0 && nodes_used_reg == CNT_W'(NODE_COUNT))
                begin
                    cursor_next     = '0;
                    depth_next      = '0;
                    res_status_next = ST_FULL;
                end
                else
                begin
                    if (cs_found_reg == '0)
                    begin
                        nm_we           = 1'b1;
                        nm_waddr        = nxt_idx;
                        nm_wdata.sym    = cs_sym_reg;
                        nm_wdata.sib    = cs_head_reg.child;
                        nm_wdata.is_end = last_reg;
                        nm_wdata.len    = last_reg ? depth_inc : '0;
                        nm_wdata.num    = last_reg ? patterns_reg[ID_W-1:0] : '0;
                        nodes_used_next = nodes_used_reg + CNT_W'(1);
                        if (cursor_reg == '0)
                        begin
                            root_child_next = nxt_idx;
                        end
                        else
                        begin
                            link_addr_next       = cursor_reg;
                            link_word_next       = cs_head_reg;
                            link_word_next.child = nxt_idx;
                            state_next           = S_INS_LINK;
                        end
                    end
                    else if (last_reg)
                    begin
                        nm_we           = 1'b1;
                        nm_waddr        = cs_found_reg;
                        nm_wdata        = cs_word_reg;
                        nm_wdata.is_end = 1'b1;
                        nm_wdata.len    = depth_inc;
                        nm_wdata.num    = patterns_reg[ID_W-1:0];
                    end
                    if (last_reg)
                    begin
                        res_id_next   = patterns_reg[ID_W-1:0];
                        patterns_next = patterns_reg + PAT_W'(1);
                        cursor_next   = '0;
                        depth_next    = '0;
                    end
                    else
                    begin
                        cursor_next = (cs_found_reg == '0) ? nxt_idx : cs_found_reg;
                        depth_next  = depth_inc;
                    end
                end
            end

            S_INS_LINK:
            begin
                nm_we      = 1'b1;
                nm_waddr   = link_addr_reg;
                nm_wdata   = link_word_reg;
                state_next = S_DONE;
            end

            // Text: follow a child or drop to the failure link
            S_TX_STEP:
            begin
                if (cs_found_reg != '0)
                begin
                    match_state_next = cs_found_reg;
                    node_next        = cs_found_reg;
                    nm_re            = 1'b1;
                    nm_raddr         = cs_found_reg;
                    state_next       = S_TX_WALK;
                end
                else if (node_reg == '0)
                begin
                    match_state_next = '0;
                    state_next       = S_TX_FIN;
                end
                else
                begin
                    node_next  = cs_head_reg.fail;
                    nm_re      = 1'b1;
                    nm_raddr   = cs_head_reg.fail;
                    state_next = S_CS_HEAD;
                end
            end

            // Walk the failure chain and report pattern ends
            S_TX_WALK:
            begin
                if (node_reg == '0 || cnt_reg == RES_W'(RESULT_CAP))
                begin
                    state_next = S_TX_FIN;
                end
                else if (rword.is_end && pend_valid_reg && !out_free)
                begin
                    state_next = S_TX_WALK;
                end
                else
                begin
                    if (rword.is_end)
                    begin
                        if (pend_valid_reg)
                        begin
                            push        = 1'b1;
                            push_status = ST_MATCH;
                            push_id     = pend_id_reg;
                            push_sp     = pend_sp_reg;
                            push_ep     = pos_reg;
                            push_last   = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_id_next    = rword.num;
                        pend_sp_next    = pos_reg - 32'(rword.len) + 32'd1;
                        cnt_next        = cnt_reg + RES_W'(1);
                    end
                    node_next = rword.fail;
                    nm_re     = 1'b1;
                    nm_raddr  = rword.fail;
                end
            end

            S_TX_FIN:
            begin
                if (out_free)
                begin
                    push = 1'b1;
                    if (pend_valid_reg)
                    begin
                        push_status = ST_MATCH;
                        push_id     = pend_id_reg;
                        push_sp     = pend_sp_reg;
                        push_ep     = pos_reg;
                    end
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end

            // Build: pop the next queued node
            S_B_POP:
            begin
                if (head_reg == tail_reg)
                begin
                    res_status_next = ST_OK;
                    res_id_next     = '0;
                    state_next      = S_DONE;
                end
                else
                begin
                    qm_re      = 1'b1;
                    qm_raddr   = head_reg[NODE_W-1:0];
                    head_next  = head_reg + CNT_W'(1);
                    state_next = S_B_QW;
                end
            end

            S_B_QW:
            begin
                nm_re      = 1'b1;
                nm_raddr   = qm_q_reg;
                state_next = S_B_NW;
            end

            S_B_NW:
            begin
                nfail_next = rword.fail;
                if (rword.child == '0)
                begin
                    state_next = S_B_POP;
                end
                else
                begin
                    node_next  = rword.child;
                    nm_re      = 1'b1;
                    nm_raddr   = rword.child;
                    state_next = S_B_KW;
                end
            end

            S_B_KW:
            begin
                kword_next  = rword;
                bf_next     = nfail_reg;
                nm_re       = 1'b1;
                nm_raddr    = nfail_reg;
                cs_sym_next = rword.sym;
                cs_ret_next = S_B_FS;
                state_next  = S_CS_HEAD;
            end

            S_B_FS:
            begin
                if (cs_found_reg != '0 && cs_found_reg != node_reg)
                begin
                    link_addr_next = cs_found_reg;
                    state_next     = S_B_WR;
                end
                else if (bf_reg == '0)
                begin
                    link_addr_next = '0;
                    state_next     = S_B_WR;
                end
                else
                begin
                    bf_next    = cs_head_reg.fail;
                    nm_re      = 1'b1;
                    nm_raddr   = cs_head_reg.fail;
                    state_next = S_CS_HEAD;
                end
            end

            // Store the failure link, enqueue the child, go to its sibling
            S_B_WR:
            begin
                nm_we         = 1'b1;
                nm_waddr      = node_reg;
                nm_wdata      = kword_reg;
                nm_wdata.fail = link_addr_reg;
                qm_we         = 1'b1;
                qm_waddr      = tail_reg[NODE_W-1:0];
                qm_wdata      = node_reg;
                tail_next     = tail_reg + CNT_W'(1);
                if (kword_reg.sib == '0)
                begin
                    state_next = S_B_POP;
                end
                else
                begin
                    node_next  = kword_reg.sib;
                    nm_re      = 1'b1;
                    nm_raddr   = kword_reg.sib;
                    state_next = S_B_KW;
                end
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    push        = 1'b1;
                    push_status = res_status_reg;
                    push_id     = res_id_reg;
                    state_next  = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Load or drain the output register
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        status_next    = status_reg;
        id_next        = id_reg;
        sp_next        = sp_reg;
        ep_next        = ep_reg;
        olast_next     = olast_reg;
        if (push)
        begin
            out_valid_next = 1'b1;
            status_next    = push_status;
            id_next        = push_id;
            sp_next        = push_sp;
            ep_next        = push_ep;
            olast_next     = push_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign pattern_id  = id_reg;
    assign start_pos   = sp_reg;
    assign end_pos     = ep_reg;
    assign last_result = olast_reg;

    // Node memory
    always_ff @(posedge clk)
    begin
        if (nm_we)
        begin
            node_mem[nm_waddr] <= nm_wdata;
        end
        if (nm_re)
        begin
            nm_q_reg <= node_mem[nm_raddr];
        end
    end

    // Queue memory
    always_ff @(posedge clk)
    begin
        if (qm_we)
        begin
            queue_mem[qm_waddr] <= qm_wdata;
        end
        if (qm_re)
        begin
            qm_q_reg <= queue_mem[qm_raddr];
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            root_child_reg  <= '0;
            nodes_used_reg  <= CNT_W'(1);
            cursor_reg      <= '0;
            depth_reg       <= '0;
            patterns_reg    <= '0;
            match_state_reg <= '0;
            text_pos_reg    <= '0;
            pend_valid_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
            rd_root_reg     <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            root_child_reg  <= root_child_next;
            nodes_used_reg  <= nodes_used_next;
            cursor_reg      <= cursor_next;
            depth_reg       <= depth_next;
            patterns_reg    <= patterns_next;
            match_state_reg <= match_state_next;
            text_pos_reg    <= text_pos_next;
            pend_valid_reg  <= pend_valid_next;
            out_valid_reg   <= out_valid_next;
            if (nm_re)
            begin
                rd_root_reg <= (nm_raddr == '0);
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        cs_sym_reg     <= cs_sym_next;
        cs_ret_reg     <= cs_ret_next;
        cs_cur_reg     <= cs_cur_next;
        cs_found_reg   <= cs_found_next;
        cs_head_reg    <= cs_head_next;
        cs_word_reg    <= cs_word_next;
        last_reg       <= last_next;
        link_addr_reg  <= link_addr_next;
        link_word_reg  <= link_word_next;
        res_status_reg <= res_status_next;
        res_id_reg     <= res_id_next;
        node_reg       <= node_next;
        pos_reg        <= pos_next;
        cnt_reg        <= cnt_next;
        pend_id_reg    <= pend_id_next;
        pend_sp_reg    <= pend_sp_next;
        head_reg       <= head_next;
        tail_reg       <= tail_next;
        nfail_reg      <= nfail_next;
        bf_reg         <= bf_next;
        kword_reg      <= kword_next;
        status_reg     <= status_next;
        id_reg         <= id_next;
        sp_reg         <= sp_next;
        ep_reg         <= ep_next;
        olast_reg      <= olast_next;
    end

`ifndef ASSERT_OFF
    a_nodes_bound: assert property (@(posedge clk) disable iff (!rst_n)
        nodes_used_reg >= CNT_W'(1) && nodes_used_reg <= CNT_W'(NODE_COUNT))
        else $error("node count out of range");

    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= LEN_W'(MAX_PATTERN_LEN))
        else $error("insert depth out of range");

    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(nm_we && nm_re && nm_waddr == nm_raddr))
        else $error("node memory read and write hit the same entry");

    a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !pend_valid_reg)
        else $error("pending match left behind at idle");

    a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> out_free)
        else $error("result pushed into a busy output register");
`endif

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the multi-pattern string matcher: directed table
// then random pattern/build/text traffic, checked against a trie predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import mpsm_pkg::*;

    localparam int WATCHDOG_LIMIT = 200000;
    localparam logic [1:0] ACT_NOP = 2'd3;

    typedef struct packed {
        logic [1:0]  act;
        logic [15:0] sym;
        logic        last;
        logic        restart;
    } request_t;

    typedef struct packed {
        logic [2:0]  st;
        logic [7:0]  id;
        logic [31:0] sp;
        logic [31:0] ep;
        logic        fin;
    } match_t;

    // directed row: typed expectation applies only when has_exp
    typedef struct packed {
        request_t req;
        logic     has_exp;
        match_t   exp;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  action;
    logic [15:0] symbol;
    logic        pattern_last;
    logic        text_start;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  status;
    logic [7:0]  pattern_id;
    logic [31:0] start_pos;
    logic [31:0] end_pos;
    logic        last_result;

    multi_pattern_string_matcher u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .symbol       (symbol),
        .pattern_last (pattern_last),
        .text_start   (text_start),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .pattern_id   (pattern_id),
        .start_pos    (start_pos),
        .end_pos      (end_pos),
        .last_result  (last_result)
    );

    // trie shadow
    logic [15:0] t_sym   [NODE_COUNT];
    logic [9:0]  t_child [NODE_COUNT];
    logic [9:0]  t_sib   [NODE_COUNT];
    logic [9:0]  t_fail  [NODE_COUNT];
    logic        t_end   [NODE_COUNT];
    logic [4:0]  t_len   [NODE_COUNT];
    logic [7:0]  t_num   [NODE_COUNT];
    int unsigned n_used, cursor, depth, n_pat, cur_state;
    logic [31:0] text_pos;

    match_t pending_matches[$];
    int     errors;
    int     quiet_cycles;
    bit     hold_long;
    bit     calm;

    function automatic int unsigned find_child(int unsigned n, logic [15:0] s);
        int unsigned c;
        c = t_child[n];
        while (c != 0) begin
            if (t_sym[c] == s)
                return c;
            c = t_sib[c];
        end
        return 0;
    endfunction

    task automatic trie_clear();
        for (int i = 0; i < NODE_COUNT; i++)
        begin
            t_sym[i] = 0; t_child[i] = 0; t_sib[i] = 0; t_fail[i] = 0;
            t_end[i] = 0; t_len[i] = 0; t_num[i] = 0;
        end
        n_used = 1; cursor = 0; depth = 0; n_pat = 0; cur_state = 0;
        text_pos = 0;
    endtask

    function automatic match_t mk(logic [2:0] st, logic [7:0] id, logic [31:0] sp,
                                  logic [31:0] ep, logic fin);
        match_t m;
        m.st = st; m.id = id; m.sp = sp; m.ep = ep; m.fin = fin;
        return m;
    endfunction

    task automatic add_pattern_symbol(request_t r, output match_t m);
        int unsigned nxt;
        m = mk(ST_OK, 0, 0, 0, 1);
        if (r.sym == 0) begin
            m.st = ST_BAD_SYM;
            return;
        end
        if (depth >= MAX_PATTERN_LEN) begin
            cursor = 0; depth = 0; m.st = ST_TOO_LONG;
            return;
        end
        if (r.last && n_pat >= MAX_PATTERNS) begin
            cursor = 0; depth = 0; m.st = ST_FULL;
            return;
        end
        nxt = find_child(cursor, r.sym);
        if (nxt == 0) begin
            if (n_used >= NODE_COUNT) begin
                cursor = 0; depth = 0; m.st = ST_FULL;
                return;
            end
            nxt = n_used;
            n_used++;
            t_sym[nxt] = r.sym; t_child[nxt] = 0; t_sib[nxt] = t_child[cursor];
            t_child[cursor] = 10'(nxt); t_fail[nxt] = 0; t_end[nxt] = 0;
            t_len[nxt] = 0; t_num[nxt] = 0;
        end
        depth++;
        if (r.last) begin
            t_end[nxt] = 1; t_len[nxt] = 5'(depth); t_num[nxt] = n_pat[7:0];
            m.id = n_pat[7:0];
            n_pat++;
            cursor = 0; depth = 0;
        end else
            cursor = nxt;
    endtask

    // breadth-first failure links
    task automatic link_failures();
        int unsigned bfs[$];
        int unsigned c, n, k, f, g, found;
        c = t_child[0];
        while (c != 0) begin
            t_fail[c] = 0; bfs.push_back(c); c = t_sib[c];
        end
        while (bfs.size() > 0) begin
            n = bfs.pop_front();
            k = t_child[n];
            while (k != 0) begin
                f = t_fail[n];
                found = 0;
                forever begin
                    g = find_child(f, t_sym[k]);
                    if (g != 0 && g != k) begin
                        found = g;
                        break;
                    end
                    if (f == 0)
                        break;
                    f = t_fail[f];
                end
                t_fail[k] = 10'(found);
                bfs.push_back(k);
                k = t_sib[k];
            end
        end
    endtask

    task automatic scan_text(request_t r, ref match_t res[$]);
        int unsigned s, t, g;
        logic [31:0] pos;
        if (r.restart) begin
            cur_state = 0; text_pos = 0;
        end
        pos = text_pos;
        text_pos = text_pos + 1;
        s = cur_state;
        forever begin
            g = find_child(s, r.sym);
            if (g != 0) begin
                s = g;
                break;
            end
            if (s == 0)
                break;
            s = t_fail[s];
        end
        cur_state = s;
        t = s;
        while (t != 0 && res.size() < RESULT_CAP) begin
            if (t_end[t])
                res.push_back(mk(ST_MATCH, t_num[t], pos - t_len[t] + 1, pos, 0));
            t = t_fail[t];
        end
        if (res.size() == 0)
            res.push_back(mk(ST_OK, 0, 0, 0, 1));
        else
            res[res.size()-1].fin = 1;
    endtask

    // work out the results of one accepted request
    task automatic predict(request_t r, ref match_t res[$]);
        match_t m;
        case (r.act)
            ACT_PATTERN: begin add_pattern_symbol(r, m); res.push_back(m); end
            ACT_BUILD:   begin link_failures(); res.push_back(mk(ST_OK, 0, 0, 0, 1)); end
            ACT_TEXT:    scan_text(r, res);
            default: ;
        endcase
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // drive one request and wait for its acceptance; valid stays up afterwards
    task automatic send(request_t r, bit has_exp = 0, match_t exp = '0);
        match_t res[$];
        while ($urandom_range(99) < 22 && !calm) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        action       <= r.act;
        symbol       <= r.sym;
        pattern_last <= r.last;
        text_start   <= r.restart;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict(r, res);
        if (has_exp && (res.size() != 1 || res[0] != exp)) begin
            $display("%0t directed row: expected %p got %p", $time, exp, res[0]);
            errors++;
        end
        foreach (res[i])
            pending_matches.push_back(res[i]);
    endtask

    // drop valid and wait for every expected result
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_matches.size() != 0)
            @(posedge clk);
    endtask

    function automatic request_t rq(logic [1:0] a, logic [15:0] s, logic l, logic t);
        request_t r;
        r.act = a; r.sym = s; r.last = l; r.restart = t;
        return r;
    endfunction

    function automatic row_t rw(request_t r, bit h = 0, match_t e = '0);
        row_t x;
        x.req = r; x.has_exp = h; x.exp = e;
        return x;
    endfunction

    // random pattern of 1..max symbols from a small alphabet
    task automatic rand_pattern(int unsigned maxlen);
        int unsigned n;
        n = $urandom_range(maxlen, 1);
        for (int i = 0; i < n; i++)
            send(rq(ACT_PATTERN, 16'($urandom_range(4, 1)), i == n - 1,
                    1'($urandom_range(1))));
    endtask

    initial
    begin
        row_t dir[$];
        int unsigned items;
        bit hold_done, calm_done;
        errors = 0; hold_long = 0; calm = 0; hold_done = 0; calm_done = 0;
        rst_n = 1'b0; in_valid = 1'b0; action = '0; symbol = '0;
        pattern_last = 1'b0; text_start = 1'b0;
        trie_clear();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty trie, bad symbol, extremes, overlapping patterns
        dir.push_back(rw(rq(ACT_TEXT, 16'h0005, 0, 1), 1, mk(ST_OK, 0, 0, 0, 1)));
        dir.push_back(rw(rq(ACT_PATTERN, 16'h0000, 1, 1), 1, mk(ST_BAD_SYM, 0, 0, 0, 1)));
        dir.push_back(rw(rq(ACT_NOP, 16'hFFFF, 1, 1)));
        dir.push_back(rw(rq(ACT_PATTERN, 16'hFFFF, 1, 0), 1, mk(ST_OK, 0, 0, 0, 1)));
        dir.push_back(rw(rq(ACT_PATTERN, 16'h0001, 0, 1)));
        dir.push_back(rw(rq(ACT_PATTERN, 16'h0002, 1, 0)));
        dir.push_back(rw(rq(ACT_PATTERN, 16'h0002, 1, 0)));
        dir.push_back(rw(rq(ACT_PATTERN, 16'h0001, 0, 0)));
        dir.push_back(rw(rq(ACT_PATTERN, 16'h0002, 1, 0)));
        dir.push_back(rw(rq(ACT_BUILD, 16'hAAAA, 1, 1), 1, mk(ST_OK, 0, 0, 0, 1)));
        dir.push_back(rw(rq(ACT_TEXT, 16'h0002, 1, 1)));
        dir.push_back(rw(rq(ACT_TEXT, 16'h0001, 0, 0)));
        dir.push_back(rw(rq(ACT_TEXT, 16'h0002, 0, 0)));
        dir.push_back(rw(rq(ACT_TEXT, 16'hFFFF, 0, 0)));
        dir.push_back(rw(rq(ACT_TEXT, 16'h0000, 0, 0)));
        // node inserted after the build keeps the root as fail link
        dir.push_back(rw(rq(ACT_PATTERN, 16'h0003, 1, 0)));
        dir.push_back(rw(rq(ACT_TEXT, 16'h0003, 0, 0)));
        foreach (dir[i])
            send(dir[i].req, dir[i].has_exp, dir[i].exp);
        // pattern too long: 17 symbols without a final one
        for (int i = 0; i <= MAX_PATTERN_LEN; i++)
            send(rq(ACT_PATTERN, 16'h8000 | 16'(i), 0, 0));
        drain();

        // random: a mix of pattern growth, builds and text scans; mostly well-formed
        items = 0;
        while (items < 186) begin
            if (items >= 60 && !hold_done) begin
                hold_long = 1;
                hold_done = 1;
            end
            if (items >= 110 && !calm_done) begin
                drain();
                calm = 1;
                calm_done = 1;
            end
            if (items >= 150)
                calm = 0;
            case ($urandom_range(9))
                0, 1, 2: begin rand_pattern(5); items += 3; end
                3:       begin send(rq(ACT_BUILD, 16'($urandom), 0, 0)); items++; end
                4:       begin
                    send(rq(2'($urandom_range(3)), 16'($urandom), 1'($urandom_range(1)),
                            1'($urandom_range(1))));
                    items++;
                end
                default: begin
                    send(rq(ACT_TEXT, 16'($urandom_range(4, 0)), 0, $urandom_range(15) == 0));
                    items++;
                end
            endcase
        end
        drain();
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

    // receiver: random stalls, one long hold-off
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (hold_long) begin
                out_ready <= 1'b0;
                repeat (400) @(posedge clk);
                hold_long = 0;
            end
            out_ready <= calm || ($urandom_range(99) >= 22);
        end
    end

    // compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        match_t got;
        if (rst_n && out_valid && out_ready) begin
            got = mk(status, pattern_id, start_pos, end_pos, last_result);
            if (pending_matches.size() == 0) begin
                $display("%0t unexpected result: expected none got %p", $time, got);
                errors++;
            end else begin
                if (got != pending_matches[0]) begin
                    $display("%0t mismatch: expected %p got %p", $time,
                             pending_matches[0], got);
                    errors++;
                end
                void'(pending_matches.pop_front());
            end
        end
    end

    // watchdog on cycles with no transfer
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    initial quiet_cycles = 0;
endmodule
